FILE: rtl/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

    // Capture counter and result widths
    localparam int CNT_W   = 16;
    localparam int COUNT_W = 16;
    localparam int PRE_W   = 10;
    localparam int TICK_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SEL_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 2'd1;

    // Prescaler selections
    localparam logic [SEL_W-1:0] PRE_DIV1    = 3'd1;
    localparam logic [SEL_W-1:0] PRE_DIV8    = 3'd2;
    localparam logic [SEL_W-1:0] PRE_DIV64   = 3'd3;
    localparam logic [SEL_W-1:0] PRE_DIV256  = 3'd4;
    localparam logic [SEL_W-1:0] PRE_DIV1024 = 3'd5;

    localparam logic [SEL_W-1:0]  PRESCALE_RESET = PRE_DIV64;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 16'd100;

    // Measurement phase codes
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;

    // Terminal prescaler value for a selection; run flags a running counter
    typedef struct packed {
        logic             run;
        logic [PRE_W-1:0] last;
    } pre_cfg_t;

    function automatic pre_cfg_t pre_decode(input logic [SEL_W-1:0] sel);
        pre_cfg_t r;
        r.run  = 1'b1;
        r.last = '0;
        unique case (sel)
            PRE_DIV1:    r.last = 10'd0;
            PRE_DIV8:    r.last = 10'd7;
            PRE_DIV64:   r.last = 10'd63;
            PRE_DIV256:  r.last = 10'd255;
            PRE_DIV1024: r.last = 10'd1023;
            default:     r.run  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ppc_in_if.sv
`timescale 1ns / 1ps

interface ppc_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic measure_period;
    logic pin_level;
    logic timebase_tick;

    modport source (output valid, start_req, measure_period, pin_level, timebase_tick,
                    input ready);
    modport sink   (input valid, start_req, measure_period, pin_level, timebase_tick,
                    output ready);
endinterface

FILE: rtl/ppc_out_if.sv
`timescale 1ns / 1ps

interface ppc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        success;
    logic [ppc_pkg::COUNT_W-1:0] count;

    modport source (output valid, success, count, input ready);
    modport sink   (input valid, success, count, output ready);
endinterface

FILE: rtl/ppc_cfg_if.sv
`timescale 1ns / 1ps

interface ppc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ppc_pkg::CFG_IDX_W-1:0]  index;
    logic [ppc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ppc_timer.sv
`timescale 1ns / 1ps

module ppc_timer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [ppc_pkg::SEL_W-1:0]   prescale_select,
    output logic [ppc_pkg::CNT_W-1:0]   timer_count
);

    logic [ppc_pkg::PRE_W-1:0] pre_reg;
    logic [ppc_pkg::PRE_W-1:0] pre_next;
    logic [ppc_pkg::CNT_W-1:0] cnt_reg;
    logic [ppc_pkg::CNT_W-1:0] cnt_next;
    ppc_pkg::pre_cfg_t         pre_cfg;

    assign pre_cfg = ppc_pkg::pre_decode(prescale_select);

    // Prescaler wraps at its terminal value; unused selections freeze both
    always_comb
    begin
        pre_next = pre_reg;
        cnt_next = cnt_reg;
        if (step && pre_cfg.run)
        begin
            if (pre_reg >= pre_cfg.last)
            begin
                pre_next = '0;
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                pre_next = pre_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            pre_reg <= pre_next;
            cnt_reg <= cnt_next;
        end
    end

    assign timer_count = cnt_reg;

endmodule

FILE: rtl/pulse_period_capture_core.sv
`timescale 1ns / 1ps

// Input capture for a high pulse width or a rising-to-rising period. Each input word is one
// sample of the pin together with a timebase tick and an optional start request; the
// prescaler advances once per processed word, not per clock, and the 16-bit capture counter
// advances once each time the prescaler wraps. Words are taken one per cycle unless the
// input stalls: a word waits in the input register, and its result, if any, is registered
// in the output register. Throughput is set by the output register: input ready follows
// output ready combinationally while a word sits in the input register behind a held
// result, and the input stalls only then, when the sink is not ready.
// At most one result (success and count, or failure with count zero) comes from each word.
// Configuration writes are always taken and should be made with no measurement in flight.
module pulse_period_capture_core
(
    input  logic      clk,
    input  logic      rst_n,
    ppc_in_if.sink    in_ch,
    ppc_out_if.source out_ch,
    ppc_cfg_if.sink   cfg
);

    // Configuration registers
    logic [ppc_pkg::SEL_W-1:0]  sel_reg;
    logic [ppc_pkg::TICK_W-1:0] timeout_reg;

    // Input register
    logic s1_valid_reg;
    logic s1_start_reg;
    logic s1_mode_reg;
    logic s1_pin_reg;
    logic s1_tick_reg;

    // Measurement state
    logic [ppc_pkg::PHASE_W-1:0] phase_reg;
    logic [ppc_pkg::PHASE_W-1:0] phase_next;
    logic                        mode_reg;
    logic                        mode_next;
    logic [ppc_pkg::CNT_W-1:0]   first_reg;
    logic [ppc_pkg::CNT_W-1:0]   first_next;
    logic [ppc_pkg::TICK_W-1:0]  wait_reg;
    logic [ppc_pkg::TICK_W-1:0]  wait_next;
    logic                        last_pin_reg;

    // Output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        success_reg;
    logic [ppc_pkg::COUNT_W-1:0] count_reg;

    logic                        advance;
    logic                        in_fire;
    logic                        rising;
    logic                        falling;
    logic                        hit;
    logic [ppc_pkg::TICK_W-1:0]  wait_inc;
    logic                        timed_out;
    logic                        res_valid;
    logic                        res_success;
    logic [ppc_pkg::COUNT_W-1:0] res_count;
    logic [ppc_pkg::CNT_W-1:0]   timer_count;
    logic [ppc_pkg::CNT_W-1:0]   diff;

    // Handshakes
    assign advance      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg.ready    = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= ppc_pkg::PRESCALE_RESET;
            timeout_reg <= ppc_pkg::TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ppc_pkg::REG_PRESCALE_SELECT: sel_reg     <= cfg.data[ppc_pkg::SEL_W-1:0];
                ppc_pkg::REG_TIMEOUT_TICKS:   timeout_reg <= cfg.data[ppc_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_start_reg <= in_ch.start_req;
            s1_mode_reg  <= in_ch.measure_period;
            s1_pin_reg   <= in_ch.pin_level;
            s1_tick_reg  <= in_ch.timebase_tick;
        end
    end

    // Capture counter, stepped once per processed word
    ppc_timer u_timer
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .prescale_select (sel_reg),
        .timer_count     (timer_count)
    );

    // Edge detect and timeout
    assign rising    = s1_pin_reg && !last_pin_reg;
    assign falling   = !s1_pin_reg && last_pin_reg;
    assign hit       = mode_reg ? rising : falling;
    assign wait_inc  = wait_reg + 1'b1;
    assign timed_out = s1_tick_reg && (wait_inc >= timeout_reg);
    assign diff      = timer_count - first_reg;

    // Phase sequencing; a timeout beats an edge in the same word
    always_comb
    begin
        phase_next  = phase_reg;
        mode_next   = mode_reg;
        first_next  = first_reg;
        wait_next   = wait_reg;
        res_valid   = 1'b0;
        res_success = 1'b0;
        res_count   = '0;
        if (phase_reg == ppc_pkg::PH_FIRST || phase_reg == ppc_pkg::PH_SECOND)
        begin
            if (s1_tick_reg)
                wait_next = wait_inc;
            priority if (timed_out)
            begin
                res_valid  = 1'b1;
                phase_next = ppc_pkg::PH_IDLE;
                wait_next  = '0;
            end
            else if (phase_reg == ppc_pkg::PH_FIRST)
            begin
                if (rising)
                begin
                    first_next = timer_count;
                    wait_next  = '0;
                    phase_next = ppc_pkg::PH_SECOND;
                end
            end
            else if (hit)
            begin
                res_valid   = 1'b1;
                res_success = 1'b1;
                res_count   = ppc_pkg::COUNT_W'(diff);
                phase_next  = ppc_pkg::PH_IDLE;
                wait_next   = '0;
            end
        end
        else
        begin
            phase_next = ppc_pkg::PH_IDLE;
            if (s1_start_reg)
            begin
                mode_next  = s1_mode_reg;
                wait_next  = '0;
                phase_next = ppc_pkg::PH_FIRST;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ppc_pkg::PH_IDLE;
            mode_reg     <= 1'b0;
            first_reg    <= '0;
            wait_reg     <= '0;
            last_pin_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            mode_reg     <= mode_next;
            first_reg    <= first_next;
            wait_reg     <= wait_next;
            last_pin_reg <= s1_pin_reg;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            success_reg <= res_success;
            count_reg   <= res_count;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.success = success_reg;
    assign out_ch.count   = count_reg;

    // A word taken always lands in the input register
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted word lost before processing");

    // Every result ends the measurement
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid) |=> (phase_reg == ppc_pkg::PH_IDLE))
        else $error("measurement still running after a result");

    // Wait counter is clear whenever no measurement runs
    a_idle_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ppc_pkg::PH_IDLE) |-> (wait_reg == '0))
        else $error("wait counter not cleared in idle");

    // Failure carries a zero count
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !success_reg) |-> (count_reg == '0))
        else $error("timeout result with non-zero count");

endmodule

FILE: tb/pulse_period_capture_core_tb.sv
`timescale 1ns / 1ps

module pulse_period_capture_core_tb;

    localparam int LIMIT_CYC  = 200000;
    localparam int SETTLE_CYC = 6;
    localparam int HOLD_AT    = 600;   // words taken before the long sink hold-off
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_WORDS = 125;
    localparam int MAX_SHOWN  = 100;

    // Prescaler codes outside the divider table: the counter stands still
    localparam logic [ppc_pkg::SEL_W-1:0] SEL_STOP_ZERO = 3'd0;
    localparam logic [ppc_pkg::SEL_W-1:0] SEL_STOP_SIX  = 3'd6;
    localparam logic [ppc_pkg::SEL_W-1:0] SEL_STOP_TOP  = 3'd7;

    typedef struct packed {
        logic start_req;
        logic measure_period;
        logic pin_level;
        logic timebase_tick;
    } pin_word_t;

    typedef struct packed {
        logic                        success;
        logic [ppc_pkg::COUNT_W-1:0] count;
    } capture_t;

    typedef struct {
        logic [ppc_pkg::SEL_W-1:0]  sel;
        logic [ppc_pkg::TICK_W-1:0] ticks;
        int                         tick_pct;
    } setting_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b1;

    ppc_in_if  in_ch ();
    ppc_out_if out_ch ();
    ppc_cfg_if cfg ();

    pulse_period_capture_core DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Words waiting for the driver, and measurement results still due
    pin_word_t pending_words [$];
    capture_t  awaited [$];

    int words_queued   = 0;
    int words_taken    = 0;
    int directed_words = 0;
    int cfg_writes     = 0;
    int done_ok        = 0;
    int done_timeout   = 0;
    int errors         = 0;
    int cycles         = 0;
    logic [ppc_pkg::COUNT_W-1:0] widest = '0;

    // Capture state as the block should hold it
    logic [ppc_pkg::SEL_W-1:0]   p_sel;
    logic [ppc_pkg::TICK_W-1:0]  p_timeout;
    logic [ppc_pkg::CNT_W-1:0]   p_timer;
    logic [ppc_pkg::PRE_W-1:0]   p_pre;
    logic [ppc_pkg::PHASE_W-1:0] p_phase;
    logic                        p_period;
    logic [ppc_pkg::CNT_W-1:0]   p_first;
    logic [ppc_pkg::TICK_W-1:0]  p_wait;
    logic                        p_last_pin;

    always #10 clk = ~clk;

    // One sampled word: edge detection, phase step, then counter advance
    function automatic void advance_capture(input pin_word_t w);
        logic rising;
        logic falling;
        logic timed_out;
        logic hit;
        int   ratio;
        rising  = w.pin_level && !p_last_pin;
        falling = !w.pin_level && p_last_pin;
        if (p_phase == ppc_pkg::PH_FIRST || p_phase == ppc_pkg::PH_SECOND) begin
            timed_out = 1'b0;
            if (w.timebase_tick) begin
                p_wait    = p_wait + 1'b1;
                timed_out = (p_wait >= p_timeout);
            end
            if (timed_out) begin
                // failure wins over an edge in the same word
                awaited.push_back('{success: 1'b0, count: '0});
                p_phase = ppc_pkg::PH_IDLE;
                p_wait  = '0;
            end
            else if (p_phase == ppc_pkg::PH_FIRST) begin
                if (rising) begin
                    p_first = p_timer;
                    p_wait  = '0;
                    p_phase = ppc_pkg::PH_SECOND;
                end
            end
            else begin
                hit = p_period ? rising : falling;
                if (hit) begin
                    awaited.push_back('{success: 1'b1,
                                        count: ppc_pkg::COUNT_W'(p_timer - p_first)});
                    p_phase = ppc_pkg::PH_IDLE;
                    p_wait  = '0;
                end
            end
        end
        else begin
            p_phase = ppc_pkg::PH_IDLE;
            if (w.start_req) begin
                p_period = w.measure_period;
                p_wait   = '0;
                p_phase  = ppc_pkg::PH_FIRST;
            end
        end

        case (p_sel)
            ppc_pkg::PRE_DIV1:    ratio = 1;
            ppc_pkg::PRE_DIV8:    ratio = 8;
            ppc_pkg::PRE_DIV64:   ratio = 64;
            ppc_pkg::PRE_DIV256:  ratio = 256;
            ppc_pkg::PRE_DIV1024: ratio = 1024;
            default:              ratio = 0;
        endcase
        if (ratio != 0) begin
            if (int'(p_pre) + 1 >= ratio) begin
                p_pre   = '0;
                p_timer = p_timer + 1'b1;
            end
            else begin
                p_pre = p_pre + 1'b1;
            end
        end
        p_last_pin = w.pin_level;
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic [ppc_pkg::COUNT_W-1:0] want,
                                          input logic [ppc_pkg::COUNT_W-1:0] got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t ns: %s mismatch, expected 0x%h, got 0x%h", $time, what, want, got);
    endfunction

    // Stimulus helpers
    function automatic void offer(input logic s, input logic m, input logic p, input logic t);
        pending_words.push_back('{s, m, p, t});
        words_queued++;
    endfunction

    function automatic logic roll(input int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 6);
    endfunction

    // A start followed by a short pulse train; now and then pure noise instead
    function automatic void queue_episode(input int tick_pct);
        int lo;
        int hi;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(4, 20))
                offer(roll(10), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      roll(tick_pct));
        end
        else begin
            offer(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), roll(tick_pct));
            repeat ($urandom_range(1, 3)) begin
                lo = pick_run();
                hi = pick_run();
                repeat (lo) offer(roll(4), 1'($urandom_range(0, 1)), 1'b0, roll(tick_pct));
                repeat (hi) offer(roll(4), 1'($urandom_range(0, 1)), 1'b1, roll(tick_pct));
            end
        end
    endfunction

    // Two full pulses close any measurement still open
    function automatic void queue_flush();
        offer(1'b0, 1'b0, 1'b0, 1'b0);
        offer(1'b0, 1'b0, 1'b1, 1'b0);
        offer(1'b0, 1'b0, 1'b0, 1'b0);
        offer(1'b0, 1'b0, 1'b1, 1'b0);
        offer(1'b0, 1'b0, 1'b0, 1'b0);
    endfunction

    task automatic settle();
        while (words_taken != words_queued || awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ppc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n) begin : feed
        int        burst_left;
        int        gap_left;
        pin_word_t nxt;
        if (!rst_n) begin
            in_ch.valid          <= 1'b0;
            in_ch.start_req      <= 1'b0;
            in_ch.measure_period <= 1'b0;
            in_ch.pin_level      <= 1'b0;
            in_ch.timebase_tick  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left != 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_words.size() == 0) begin
                in_ch.valid <= 1'b0;
            end
            else begin
                nxt = pending_words.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.start_req      <= nxt.start_req;
                in_ch.measure_period <= nxt.measure_period;
                in_ch.pin_level      <= nxt.pin_level;
                in_ch.timebase_tick  <= nxt.timebase_tick;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                end
                else begin
                    burst_left--;
                end
            end
        end
    end

    // Sink: rotating stall pattern, plus one long hold-off
    always @(posedge clk or negedge rst_n) begin : drain_side
        logic [7:0] stall_pat;
        logic [2:0] pat_pos;
        int         pat_age;
        int         hold_left;
        logic       hold_done;
        logic       ready_n;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_pat = 8'hFF;
            pat_pos   = '0;
            pat_age   = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else begin
            if (hold_left != 0) begin
                hold_left--;
                ready_n = 1'b0;
            end
            else if (!hold_done && words_taken >= HOLD_AT) begin
                hold_left = HOLD_LEN - 1;
                hold_done = 1'b1;
                ready_n   = 1'b0;
            end
            else begin
                if (pat_age == 0) begin
                    stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
                    pat_age   = 48;
                end
                pat_age--;
                ready_n = stall_pat[pat_pos];
                pat_pos = pat_pos + 1'b1;
            end
            out_ch.ready <= ready_n;
        end
    end

    // Monitor: register writes, accepted words and results
    always @(posedge clk or negedge rst_n) begin : observe
        capture_t got;
        capture_t want;
        if (!rst_n) begin
            p_sel      = ppc_pkg::PRESCALE_RESET;
            p_timeout  = ppc_pkg::TIMEOUT_RESET;
            p_timer    = '0;
            p_pre      = '0;
            p_phase    = ppc_pkg::PH_IDLE;
            p_period   = 1'b0;
            p_first    = '0;
            p_wait     = '0;
            p_last_pin = 1'b0;
            awaited.delete();
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                cfg_writes++;
                case (cfg.index)
                    ppc_pkg::REG_PRESCALE_SELECT: p_sel = cfg.data[ppc_pkg::SEL_W-1:0];
                    ppc_pkg::REG_TIMEOUT_TICKS:   p_timeout = cfg.data[ppc_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.success = out_ch.success;
                got.count   = out_ch.count;
                if (awaited.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t ns: unexpected result, expected none, %s %0b count 0x%h",
                                 $time, "got success", got.success, got.count);
                end
                else begin
                    want = awaited.pop_front();
                    if (got.success !== want.success)
                        note_mismatch("success", ppc_pkg::COUNT_W'(want.success),
                                      ppc_pkg::COUNT_W'(got.success));
                    if (got.count !== want.count)
                        note_mismatch("count", want.count, got.count);
                    if (want.success) begin
                        done_ok++;
                        if (want.count > widest)
                            widest = want.count;
                    end
                    else begin
                        done_timeout++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                words_taken++;
                advance_capture('{in_ch.start_req, in_ch.measure_period,
                                  in_ch.pin_level, in_ch.timebase_tick});
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYC) begin
            $display("Watchdog expired: %0d of %0d words taken, %0d results outstanding",
                     words_taken, words_queued, awaited.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        setting_t plan [8];
        int       phase_start;
        cfg.valid = 1'b0;
        cfg.index = ppc_pkg::REG_PRESCALE_SELECT;
        cfg.data  = '0;
        rst_n <= 1'b0;

        plan[0] = '{ppc_pkg::PRE_DIV1,    16'hFFFF, 40};
        plan[1] = '{ppc_pkg::PRE_DIV8,    16'd3,    10};
        plan[2] = '{ppc_pkg::PRE_DIV1024, 16'd12,    5};
        plan[3] = '{ppc_pkg::PRE_DIV256,  16'd0,     3};
        plan[4] = '{ppc_pkg::PRE_DIV64,   16'd100,  50};
        plan[5] = '{SEL_STOP_ZERO,        16'd40,   10};
        plan[6] = '{SEL_STOP_TOP,         16'd8,    10};
        plan[7] = '{SEL_STOP_SIX,         16'hFFFF, 10};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: edge in the start word is not captured, start while busy
        offer(1'b1, 1'b0, 1'b1, 1'b0);
        offer(1'b0, 1'b1, 1'b1, 1'b0);
        offer(1'b0, 1'b0, 1'b0, 1'b0);   // falling edge while waiting for a rise
        offer(1'b1, 1'b1, 1'b1, 1'b0);   // rise captured, start ignored
        offer(1'b0, 1'b0, 1'b1, 1'b1);
        offer(1'b0, 1'b0, 1'b0, 1'b0);   // width done
        offer(1'b1, 1'b1, 1'b0, 1'b0);
        offer(1'b0, 1'b0, 1'b1, 1'b0);
        offer(1'b0, 1'b1, 1'b0, 1'b0);   // fall ignored in period mode
        offer(1'b0, 1'b0, 1'b1, 1'b0);   // period done
        offer(1'b0, 1'b0, 1'b0, 1'b0);
        settle();

        // Short timeout: failure together with an edge in both waits
        write_reg(ppc_pkg::REG_PRESCALE_SELECT, 16'(ppc_pkg::PRE_DIV1));
        write_reg(ppc_pkg::REG_TIMEOUT_TICKS, 16'd2);
        offer(1'b1, 1'b0, 1'b0, 1'b0);
        offer(1'b0, 1'b0, 1'b1, 1'b1);
        offer(1'b0, 1'b0, 1'b1, 1'b1);
        offer(1'b0, 1'b0, 1'b0, 1'b1);   // fall and timeout together
        offer(1'b1, 1'b1, 1'b0, 1'b0);
        offer(1'b0, 1'b0, 1'b0, 1'b1);
        offer(1'b0, 1'b0, 1'b1, 1'b1);   // rise and timeout together
        settle();

        // Zero timeout fails on the first tick
        write_reg(ppc_pkg::REG_TIMEOUT_TICKS, 16'd0);
        offer(1'b1, 1'b0, 1'b0, 1'b0);
        offer(1'b0, 1'b0, 1'b0, 1'b1);
        offer(1'b1, 1'b1, 1'b1, 1'b1);
        offer(1'b0, 1'b0, 1'b0, 1'b1);
        directed_words = words_queued;

        // Random pulse trains under each setting
        foreach (plan[i]) begin
            settle();
            write_reg(ppc_pkg::REG_PRESCALE_SELECT, 16'(plan[i].sel));
            write_reg(ppc_pkg::REG_TIMEOUT_TICKS, plan[i].ticks);
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS)
                queue_episode(plan[i].tick_pct);
            queue_flush();
        end
        settle();

        $display("Covered %0d words (%0d directed) and %0d register writes over all divider codes",
                 words_taken, directed_words, cfg_writes);
        $display("Measurements closed: %0d completed, %0d timed out, widest count 0x%h",
                 done_ok, done_timeout, widest);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
